FILE: sv/lps_pkg.sv
// Package for the Lambert pixel shader: constants, register indexes and shared types.
// Used by every module of the shader; depends on nothing.
`default_nettype none
package lps_pkg;

    // Configuration register indexes.
    localparam logic [3:0] REG_ROT_X      = 4'd0;
    localparam logic [3:0] REG_ROT_Y      = 4'd1;
    localparam logic [3:0] REG_ROT_Z      = 4'd2;
    localparam logic [3:0] REG_CLAY       = 4'd3;
    localparam logic [3:0] REG_BACKGROUND = 4'd4;
    localparam logic [3:0] REG_WIREFRAME  = 4'd5;
    localparam logic [3:0] REG_VERT_NORM  = 4'd6;
    localparam logic [3:0] REG_VERT_COL   = 4'd7;

    localparam logic signed [15:0] Q14_ONE     = 16'sd16384;
    localparam logic [15:0]        LIGHT_BASE  = 16'd14418;
    localparam logic [15:0]        LIGHT_SLOPE = 16'd51117;
    localparam logic [13:0]        DARK_FACTOR = 14'd14418;
    localparam logic signed [17:0] EDGE_LIMIT  = 18'sd327;
    localparam logic [31:0]        TINY_SQ     = 32'd7;
    localparam int                 ROOT_BITS   = 17;

    typedef struct packed {
        logic [47:0] rot_x;
        logic [47:0] rot_y;
        logic [47:0] rot_z;
        logic [47:0] clay;
        logic [23:0] background;
        logic        wireframe;
        logic        vert_norm;
        logic        vert_col;
    } t_cfg;

    // Per-pixel data that rides alongside the normal math.
    typedef struct packed {
        logic             covered;
        logic             dark;
        logic [2:0][15:0] col;
    } t_side;

endpackage
`default_nettype wire

FILE: sv/lps_if.sv
// Handshake interfaces of the Lambert pixel shader: pixel in, colour out, register writes.
// Depends on nothing.
`default_nettype none
interface lps_pix_if;
    logic        valid;
    logic        ready;
    logic        covered;
    logic [15:0] bary_a;
    logic [15:0] bary_b;
    logic [15:0] normal_x;
    logic [15:0] normal_y;
    logic [15:0] normal_z;
    logic [15:0] colour_red;
    logic [15:0] colour_green;
    logic [15:0] colour_blue;
    modport source (output valid, covered, bary_a, bary_b, normal_x, normal_y, normal_z,
                    colour_red, colour_green, colour_blue, input ready);
    modport sink (input valid, covered, bary_a, bary_b, normal_x, normal_y, normal_z,
                  colour_red, colour_green, colour_blue, output ready);
endinterface

interface lps_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface lps_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [47:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/lps_cfg_regs.sv
// Configuration register file of the Lambert pixel shader.
// Depends on lps_pkg and lps_cfg_if.
`default_nettype none
module lps_cfg_regs import lps_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    lps_cfg_if.sink i_cfg,
    output t_cfg o_cfg
);
    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ROT_X:      r_cfg.rot_x      <= i_cfg.data;
                REG_ROT_Y:      r_cfg.rot_y      <= i_cfg.data;
                REG_ROT_Z:      r_cfg.rot_z      <= i_cfg.data;
                REG_CLAY:       r_cfg.clay       <= i_cfg.data;
                REG_BACKGROUND: r_cfg.background <= i_cfg.data[23:0];
                REG_WIREFRAME:  r_cfg.wireframe  <= i_cfg.data[0];
                REG_VERT_NORM:  r_cfg.vert_norm  <= i_cfg.data[0];
                REG_VERT_COL:   r_cfg.vert_col   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: sv/lps_normal.sv
// Front end: rotation of the normal, magnitude scaling and sum of squares, five stages.
// Also selects the colour and the wireframe flag. Depends on lps_pkg and lps_pix_if.
`default_nettype none
module lps_normal import lps_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_en,
    input  wire t_cfg    i_cfg,
    lps_pix_if.sink      i_pix,
    output logic         o_vld,
    output logic [31:0]  o_s,
    output logic [61:0]  o_r,
    output logic         o_tiny,
    output t_side        o_side
);
    logic [4:0] r_vld;
    t_side      r_side [0:4];

    // Stage 1: the nine products of the rotation.
    logic signed [2:0][15:0] n_n;
    logic signed [31:0]      r_prod [0:2][0:2];
    logic signed [17:0]      n_a, n_b, n_c, n_edge;
    t_side                   n_side;

    always_comb begin
        if (i_cfg.vert_norm) begin
            n_n[0] = i_pix.normal_x;
            n_n[1] = i_pix.normal_y;
            n_n[2] = i_pix.normal_z;
        end else begin
            n_n[0] = '0;
            n_n[1] = '0;
            n_n[2] = -Q14_ONE;
        end
        n_a    = 18'(signed'(i_pix.bary_a));
        n_b    = 18'(signed'(i_pix.bary_b));
        n_c    = 18'(Q14_ONE) - n_a - n_b;
        n_edge = (n_a < n_b) ? n_a : n_b;
        if (n_c < n_edge) n_edge = n_c;
        n_side.covered = i_pix.covered;
        n_side.dark    = i_cfg.wireframe && (n_edge <= EDGE_LIMIT);
        if (i_cfg.vert_col) begin
            n_side.col[0] = i_pix.colour_red;
            n_side.col[1] = i_pix.colour_green;
            n_side.col[2] = i_pix.colour_blue;
        end else begin
            n_side.col = i_cfg.clay;
        end
    end

    logic [2:0][47:0] w_rows;
    assign w_rows = {i_cfg.rot_z, i_cfg.rot_y, i_cfg.rot_x};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int i = 0; i < 3; i++) begin
                    r_prod[r][i] <= signed'(w_rows[r][16*i +: 16]) * signed'(n_n[i]);
                end
            end
            r_side[0] <= n_side;
        end
    end

    // Stage 2: row sums and magnitudes. A magnitude is at most 3 * 2^30.
    logic [31:0] r_mag [0:2];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                logic signed [33:0] v_dot;
                v_dot = 34'(r_prod[r][0]) + 34'(r_prod[r][1]) + 34'(r_prod[r][2]);
                r_mag[r] <= v_dot[33] ? 32'(-v_dot) : v_dot[31:0];
            end
            r_side[1] <= r_side[0];
        end
    end

    // Stage 3: shift all three right until the largest fits in 15 bits.
    logic [31:0] n_max;
    logic [4:0]  n_top, n_k;
    logic [14:0] r_sh [0:2];
    logic        r_kzero3;
    always_comb begin
        n_max = (r_mag[0] > r_mag[1]) ? r_mag[0] : r_mag[1];
        if (r_mag[2] > n_max) n_max = r_mag[2];
        n_top = '0;
        for (int i = 0; i < 32; i++) begin
            if (n_max[i]) n_top = 5'(i);
        end
        n_k = (n_max[31:15] != '0) ? n_top - 5'd14 : 5'd0;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) r_sh[r] <= 15'(r_mag[r] >> n_k);
            r_kzero3   <= (n_k == '0);
            r_side[2] <= r_side[1];
        end
    end

    // Stage 4: squares.
    logic [29:0] r_sq [0:2];
    logic        r_kzero4;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) r_sq[r] <= r_sh[r] * r_sh[r];
            r_kzero4   <= r_kzero3;
            r_side[3] <= r_side[2];
        end
    end

    // Stage 5: squared length and the scaled z square.
    logic [31:0] r_s;
    logic [61:0] r_r;
    logic        r_tiny;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            logic [31:0] v_s;
            v_s = 32'(r_sq[0]) + 32'(r_sq[1]) + 32'(r_sq[2]);
            r_s        <= v_s;
            r_r        <= {r_sq[2], 32'd0};
            r_tiny     <= r_kzero4 && (v_s <= TINY_SQ);
            r_side[4] <= r_side[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_pix.valid};
        end
    end

    assign o_vld  = r_vld[4];
    assign o_s    = r_s;
    assign o_r    = r_r;
    assign o_tiny = r_tiny;
    assign o_side = r_side[4];
endmodule
`default_nettype wire

FILE: sv/lps_rsqrt.sv
// Bit-per-stage search for t = |z| / length in Q1.16, seventeen stages.
// Keeps t*t*S and t*S so that each stage is adds and one compare. Depends on lps_pkg.
`default_nettype none
module lps_rsqrt import lps_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_en,
    input  wire          i_vld,
    input  wire [31:0]   i_s,
    input  wire [61:0]   i_r,
    input  wire          i_tiny,
    input  wire t_side   i_side,
    output logic         o_vld,
    output logic [16:0]  o_t,
    output logic         o_tiny,
    output t_side        o_side
);
    logic [ROOT_BITS:1] r_vld;
    logic [16:0]        r_t    [1:ROOT_BITS];
    logic [67:0]        r_p    [1:ROOT_BITS];
    logic [49:0]        r_q    [1:ROOT_BITS];
    logic [31:0]        r_s    [1:ROOT_BITS];
    logic [61:0]        r_r    [1:ROOT_BITS];
    logic               r_tiny [1:ROOT_BITS];
    t_side              r_side [1:ROOT_BITS];

    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_stage
        localparam int B = ROOT_BITS - 1 - g;
        logic        w_vld;
        logic [16:0] w_t;
        logic [67:0] w_p;
        logic [49:0] w_q;
        logic [31:0] w_s;
        logic [61:0] w_r;
        logic        w_tiny;
        t_side       w_side;
        logic [67:0] n_cand;
        logic        n_ok;

        // The first stage starts the search from the front-end word.
        if (g == 0) begin : g_head
            assign w_vld  = i_vld;
            assign w_t    = '0;
            assign w_p    = '0;
            assign w_q    = '0;
            assign w_s    = i_s;
            assign w_r    = i_r;
            assign w_tiny = i_tiny;
            assign w_side = i_side;
        end else begin : g_body
            assign w_vld  = r_vld[g];
            assign w_t    = r_t[g];
            assign w_p    = r_p[g];
            assign w_q    = r_q[g];
            assign w_s    = r_s[g];
            assign w_r    = r_r[g];
            assign w_tiny = r_tiny[g];
            assign w_side = r_side[g];
        end

        always_comb begin
            n_cand = w_p + (68'(w_q) << (B + 1)) + (68'(w_s) << (2 * B));
            n_ok   = !w_t[16] && (n_cand <= 68'(w_r));
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_t[g+1]    <= n_ok ? (w_t | 17'(1 << B)) : w_t;
                r_p[g+1]    <= n_ok ? n_cand : w_p;
                r_q[g+1]    <= n_ok ? w_q + (50'(w_s) << B) : w_q;
                r_s[g+1]    <= w_s;
                r_r[g+1]    <= w_r;
                r_tiny[g+1] <= w_tiny;
                r_side[g+1] <= w_side;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= w_vld;
            end
        end
    end

    assign o_vld  = r_vld[ROOT_BITS];
    assign o_t    = r_t[ROOT_BITS];
    assign o_tiny = r_tiny[ROOT_BITS];
    assign o_side = r_side[ROOT_BITS];
endmodule
`default_nettype wire

FILE: sv/lps_colour.sv
// Back end: light, colour scaling, wireframe darkening and 8-bit conversion, four stages.
// The last stage is the output register. Depends on lps_pkg and lps_rgb_if.
`default_nettype none
module lps_colour import lps_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_en,
    input  wire t_cfg    i_cfg,
    input  wire          i_vld,
    input  wire [16:0]   i_t,
    input  wire          i_tiny,
    input  wire t_side   i_side,
    lps_rgb_if.source    o_rgb
);
    logic [3:0] r_vld;
    t_side      r_side [0:2];

    // Stage 1: light in Q0.16.
    logic [15:0] r_light;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            logic [16:0] v_t;
            logic [33:0] v_m;
            v_t = i_tiny ? 17'd0 : i_t;
            v_m = 34'(v_t) * 34'(LIGHT_SLOPE) + 34'd32768;
            r_light   <= LIGHT_BASE + v_m[31:16];
            r_side[0] <= i_side;
        end
    end

    // Stage 2: colour times light.
    logic [31:0] r_v [0:2];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) r_v[i] <= r_side[0].col[i] * r_light;
            r_side[1] <= r_side[0];
        end
    end

    // Stage 3: darkening near edges.
    logic [31:0] r_d [0:2];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                logic [45:0] v_m;
                v_m = 46'(r_v[i]) * 46'(DARK_FACTOR) + 46'd32768;
                r_d[i] <= r_side[1].dark ? 32'(v_m[45:16]) : r_v[i];
            end
            r_side[2] <= r_side[1];
        end
    end

    // Stage 4: clamp, scale to 8 bits, or take the background.
    logic [2:0][7:0] r_out;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                logic [31:0] v_c;
                logic [39:0] v_m;
                v_c = r_d[i][31] ? 32'h8000_0000 : r_d[i];
                v_m = 40'(v_c) * 40'd255 + 40'h40_0000_00;
                r_out[i] <= r_side[2].covered ? v_m[38:31] : i_cfg.background[8*i +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    assign o_rgb.valid     = r_vld[3];
    assign o_rgb.out_red   = r_out[0];
    assign o_rgb.out_green = r_out[1];
    assign o_rgb.out_blue  = r_out[2];
endmodule
`default_nettype wire

FILE: sv/lambert_pixel_shader_core.sv
// Two-sided Lambert pixel shader, top level.
// Path: front end, square-root search, back end; the colour word lands on the output register.
// Throughput: one pixel per cycle while the output is not stalled; the 17-stage square-root search is fully pipelined.
// Reset (synchronous, active low) clears all valid bits and every configuration register.
// A stall at the output freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none
module lambert_pixel_shader_core import lps_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    lps_cfg_if.sink  i_cfg,
    lps_pix_if.sink  i_pix,
    lps_rgb_if.source o_rgb
);
    t_cfg w_cfg;

    // The pipeline moves whenever the output register is empty or being drained.
    // Bubbles travel as words with a cleared valid bit.
    logic w_en;
    assign w_en        = !o_rgb.valid || o_rgb.ready;
    assign i_pix.ready = w_en;

    lps_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // Front end: rotate, range-reduce and square the camera-space normal.
    logic        w_f_vld, w_f_tiny;
    logic [31:0] w_f_s;
    logic [61:0] w_f_r;
    t_side       w_f_side;

    lps_normal u_normal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (w_cfg),
        .i_pix   (i_pix),
        .o_vld   (w_f_vld),
        .o_s     (w_f_s),
        .o_r     (w_f_r),
        .o_tiny  (w_f_tiny),
        .o_side  (w_f_side)
    );

    // Normalized |z| by a restoring bit search, one bit per stage.
    logic        w_r_vld, w_r_tiny;
    logic [16:0] w_r_t;
    t_side       w_r_side;

    lps_rsqrt u_rsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_f_vld),
        .i_s     (w_f_s),
        .i_r     (w_f_r),
        .i_tiny  (w_f_tiny),
        .i_side  (w_f_side),
        .o_vld   (w_r_vld),
        .o_t     (w_r_t),
        .o_tiny  (w_r_tiny),
        .o_side  (w_r_side)
    );

    // Lighting and output conversion; uncovered pixels take the background here.
    lps_colour u_colour (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (w_cfg),
        .i_vld   (w_r_vld),
        .i_t     (w_r_t),
        .i_tiny  (w_r_tiny),
        .i_side  (w_r_side),
        .o_rgb   (o_rgb)
    );
endmodule
`default_nettype wire
